[rtl/core/chst_pkg.sv]
package chst_pkg;

  // Table geometry.
  localparam int NUM_BUCKETS = 15;
  localparam int CHAIN_SLOTS = 8;
  localparam int HASH_MULT   = 94;

  // Field widths fixed by the interface.
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 64;
  localparam int TYPE_W   = 64;
  localparam int STATUS_W = 3;
  localparam int BUCKET_W = 4;
  localparam int POS_W    = 3;

  // Derived widths.
  localparam int BKT_IDX_W = $clog2(NUM_BUCKETS);
  localparam int SLOT_W    = (CHAIN_SLOTS > 1) ? $clog2(CHAIN_SLOTS) : 1;
  localparam int CNT_W     = $clog2(CHAIN_SLOTS + 1);
  localparam int DEPTH     = NUM_BUCKETS * CHAIN_SLOTS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W     = $clog2(3 * 255 + 1);
  localparam int PROD_W    = $clog2(3 * 255 * HASH_MULT + 1);
  localparam int QP_W      = 2 * PROD_W;
  // Reciprocal for the modulo: the quotient estimate is low by at most one.
  localparam int RECIP     = (2 ** PROD_W) / NUM_BUCKETS;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_PRESENT   = 3'd1,
    RES_FOUND     = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_DELETED   = 3'd4,
    RES_FULL      = 3'd5
  } res_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PROD,
    CS_QUOT,
    CS_MOD,
    CS_SCAN,
    CS_DECIDE,
    CS_SHIFT,
    CS_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  symbol_key;
    logic [TYPE_W-1:0] entry_type;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [POS_W-1:0]    position;
  } resp_t;

  typedef struct packed {
    logic [TYPE_W-1:0] entry_type;
    logic [KEY_W-1:0]  symbol_key;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic prod_en;
    logic quot_en;
    logic mod_en;
    logic scan_en;
    logic insert_en;
    logic shift_start;
    logic shift_en;
    logic len_dec;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic full;
    logic req_insert;
    logic req_delete;
    logic shift_done;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [BKT_IDX_W-1:0] bkt,
                                                  logic [SLOT_W-1:0] slot);
    slot_addr = ADDR_W'(bkt) * ADDR_W'(CHAIN_SLOTS) + ADDR_W'(slot);
  endfunction

endpackage

[rtl/core/chst_ram.sv]
module chst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/chst_ctrl.sv]
module chst_ctrl import chst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = CS_PROD;
        end
      end
      CS_PROD: begin
        cmd_o.prod_en = 1'b1;
        state_d       = CS_QUOT;
      end
      CS_QUOT: begin
        cmd_o.quot_en = 1'b1;
        state_d       = CS_MOD;
      end
      CS_MOD: begin
        cmd_o.mod_en = 1'b1;
        state_d      = CS_SCAN;
      end
      CS_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_done) begin
          state_d = CS_DECIDE;
        end
      end
      CS_DECIDE: begin
        if (stat_i.req_insert && !stat_i.found && !stat_i.full) begin
          cmd_o.insert_en = 1'b1;
          state_d         = CS_RESP;
        end else if (stat_i.req_delete && stat_i.found) begin
          cmd_o.shift_start = 1'b1;
          state_d           = CS_SHIFT;
        end else begin
          state_d = CS_RESP;
        end
      end
      CS_SHIFT: begin
        cmd_o.shift_en = 1'b1;
        if (stat_i.shift_done) begin
          cmd_o.len_dec = 1'b1;
          state_d       = CS_RESP;
        end
      end
      CS_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/chst_datapath.sv]
module chst_datapath import chst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output resp_t      out_data_o
);

  req_t                 req_q;
  logic [PROD_W-1:0]    prod_q;
  logic [PROD_W-1:0]    quot_q;
  logic [BKT_IDX_W-1:0] bucket_q;
  logic [CNT_W-1:0]     cur_len_q;
  logic [CNT_W-1:0]     len_q [NUM_BUCKETS];
  logic [CNT_W-1:0]     rd_idx_q;
  logic [SLOT_W-1:0]    cmp_idx_q;
  logic                 rd_pend_q;
  logic                 found_q;
  logic [SLOT_W-1:0]    pos_q;
  logic [CNT_W-1:0]     sh_idx_q;
  logic [SLOT_W-1:0]    wr_idx_q;
  logic                 wr_pend_q;
  logic                 out_valid_q;
  resp_t                out_q;

  logic [SUM_W-1:0]     sum;
  logic [QP_W-1:0]      qprod;
  logic [PROD_W-1:0]    qn;
  logic [PROD_W-1:0]    rem;
  logic [BKT_IDX_W-1:0] bucket_d;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  entry_t               ram_rdata;

  logic                 hit;
  logic                 scan_issue;
  logic                 shift_issue;
  logic                 full;
  resp_t                resp_d;

  // Hash: byte sum times the multiplier, then a reciprocal-based modulo.
  assign sum = SUM_W'(req_q.symbol_key[7:0]) + SUM_W'(req_q.symbol_key[15:8])
             + SUM_W'(req_q.symbol_key[23:16]);
  assign qprod = QP_W'(prod_q) * QP_W'(RECIP);

  always_comb begin
    qn  = quot_q * PROD_W'(NUM_BUCKETS);
    rem = prod_q - qn;
    if (rem >= PROD_W'(NUM_BUCKETS)) begin
      rem = rem - PROD_W'(NUM_BUCKETS);
    end
    bucket_d = BKT_IDX_W'(rem);
  end

  assign full = (cur_len_q >= CNT_W'(CHAIN_SLOTS));

  // The scan keeps one read in flight and compares the word that returns.
  assign hit         = rd_pend_q && (ram_rdata.symbol_key == req_q.symbol_key);
  assign scan_issue  = cmd_i.scan_en && !hit && (rd_idx_q < cur_len_q);
  assign shift_issue = cmd_i.shift_en && (sh_idx_q < cur_len_q);

  always_comb begin
    ram_re    = scan_issue || shift_issue;
    ram_raddr = scan_issue ? slot_addr(bucket_q, SLOT_W'(rd_idx_q))
                           : slot_addr(bucket_q, SLOT_W'(sh_idx_q));
    if (cmd_i.insert_en) begin
      ram_we    = 1'b1;
      ram_waddr = slot_addr(bucket_q, SLOT_W'(cur_len_q));
      ram_wdata = '{entry_type: req_q.entry_type, symbol_key: req_q.symbol_key};
    end else begin
      ram_we    = cmd_i.shift_en && wr_pend_q;
      ram_waddr = slot_addr(bucket_q, wr_idx_q);
      ram_wdata = ram_rdata;
    end
  end

  chst_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    if (cmd_i.prod_en) begin
      prod_q <= PROD_W'(sum) * PROD_W'(HASH_MULT);
    end
    if (cmd_i.quot_en) begin
      quot_q <= qprod[QP_W-1:PROD_W];
    end
    if (cmd_i.mod_en) begin
      bucket_q  <= bucket_d;
      cur_len_q <= len_q[bucket_d];
    end
    if (scan_issue) begin
      cmp_idx_q <= SLOT_W'(rd_idx_q);
    end
    if (cmd_i.scan_en && hit) begin
      pos_q <= cmp_idx_q;
    end
    if (shift_issue) begin
      wr_idx_q <= SLOT_W'(sh_idx_q - CNT_W'(1));
    end
    if (cmd_i.load_result) begin
      out_q <= resp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        len_q[i] <= '0;
      end
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      sh_idx_q    <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mod_en) begin
        rd_idx_q  <= '0;
        rd_pend_q <= 1'b0;
        found_q   <= 1'b0;
      end else if (cmd_i.scan_en) begin
        rd_pend_q <= scan_issue;
        if (scan_issue) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.shift_start) begin
        sh_idx_q  <= CNT_W'(pos_q) + CNT_W'(1);
        wr_pend_q <= 1'b0;
      end else if (cmd_i.shift_en) begin
        wr_pend_q <= shift_issue;
        if (shift_issue) begin
          sh_idx_q <= sh_idx_q + CNT_W'(1);
        end
      end
      if (cmd_i.insert_en) begin
        len_q[bucket_q] <= cur_len_q + CNT_W'(1);
      end else if (cmd_i.len_dec) begin
        len_q[bucket_q] <= cur_len_q - CNT_W'(1);
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    resp_d.bucket = BUCKET_W'(bucket_q);
    resp_d.status = RES_NOT_FOUND;
    resp_d.position = '0;
    if (req_q.req_type == REQ_INSERT) begin
      if (found_q) begin
        resp_d.status   = RES_PRESENT;
        resp_d.position = POS_W'(pos_q);
      end else if (full) begin
        resp_d.status = RES_FULL;
      end else begin
        resp_d.status   = RES_INSERTED;
        resp_d.position = POS_W'(cur_len_q);
      end
    end else if (req_q.req_type == REQ_DELETE) begin
      if (found_q) begin
        resp_d.status   = RES_DELETED;
        resp_d.position = POS_W'(pos_q);
      end
    end else if (found_q) begin
      resp_d.status   = RES_FOUND;
      resp_d.position = POS_W'(pos_q);
    end
  end

  assign stat_o.scan_done  = hit || (!rd_pend_q && (rd_idx_q >= cur_len_q));
  assign stat_o.found      = found_q;
  assign stat_o.full       = full;
  assign stat_o.req_insert = (req_q.req_type == REQ_INSERT);
  assign stat_o.req_delete = (req_q.req_type == REQ_DELETE);
  assign stat_o.shift_done = !wr_pend_q && (sh_idx_q >= cur_len_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.mod_en) |-> cur_len_q <= CNT_W'(CHAIN_SLOTS))
    else $error("chain length above slot count");
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.mod_en) |-> int'(bucket_q) < NUM_BUCKETS)
    else $error("bucket index out of range");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert_en |-> !full && !found_q)
    else $error("insert into full bucket or duplicate key");
  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> ram_waddr != ram_raddr)
    else $error("read and write at the same slot");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");
`endif

endmodule

[rtl/core/chained_hash_symbol_table.sv]
// Chained hash symbol table.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one request
// word: kind (insert, lookup, delete), a 64-bit symbol key and its 64-bit type.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns one result
// word per request: status, bucket index and chain position.
// A request is taken only while the controller is idle. It then computes the
// hash (byte sum times the multiplier, reciprocal quotient, remainder),
// scans the bucket's chain through the registered read port of the entry
// RAM, stopping at the first matching key, and then passes through a decision
// state and a result state. A delete that finds its key first moves the later
// entries of the chain down by one slot. The chain scan and the shift issue
// one read per cycle. No new request is taken until the result of the current
// one is loaded into the output register.
// The result sits in an output register, so the next request is accepted
// while the previous result still waits; if the receiver stalls, the block
// holds in its result cycle until that register is free.
// Reset clears the chain lengths, so the table starts empty; the entry RAM
// is not cleared, since only entries below a chain's length are ever read.
module chained_hash_symbol_table import chst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output resp_t out_data_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  chst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  chst_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import chst_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int FILL_BUCKET = 7;
  localparam int POOL_SIZE = 48;
  localparam int MAX_SHOWN = 20;

  logic  clk_i;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  req_t  in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  resp_t out_data_o;

  // Mirror of the table contents, updated as each request word is accepted.
  logic [KEY_W-1:0] key_store [NUM_BUCKETS][CHAIN_SLOTS];
  int               chain_len [NUM_BUCKETS] = '{default: 0};
  resp_t            pending_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               err_count = 0;
  int               ready_hold = 0;

  chained_hash_symbol_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [BUCKET_W-1:0] hash_bucket(logic [KEY_W-1:0] key);
    int unsigned byte_sum;
    byte_sum = int'(key[7:0]) + int'(key[15:8]) + int'(key[23:16]);
    return BUCKET_W'((byte_sum * HASH_MULT) % NUM_BUCKETS);
  endfunction

  // Random name of len bytes; the bytes above it stay zero.
  function automatic logic [KEY_W-1:0] make_name(int len);
    logic [KEY_W-1:0] sym;
    sym = {$urandom, $urandom};
    if (len < 8) sym &= (64'd1 << (8 * len)) - 64'd1;
    return sym;
  endfunction

  function automatic logic [KEY_W-1:0] make_key_in(int bkt, int len);
    logic [KEY_W-1:0] sym;
    do sym = make_name(len);
    while (int'(hash_bucket(sym)) != bkt);
    return sym;
  endfunction

  task automatic predict_request(input req_t r);
    logic [BUCKET_W-1:0] bkt;
    int    hit;
    int    n;
    resp_t res;
    bkt = hash_bucket(r.symbol_key);
    n = chain_len[bkt];
    hit = -1;
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && key_store[bkt][i] == r.symbol_key) hit = i;
    end
    res.bucket = bkt;
    res.position = '0;
    case (r.req_type)
      REQ_INSERT: begin
        if (hit >= 0) begin
          res.status = RES_PRESENT;
          res.position = POS_W'(hit);
        end else if (n >= CHAIN_SLOTS) begin
          res.status = RES_FULL;
        end else begin
          key_store[bkt][n] = r.symbol_key;
          chain_len[bkt] = n + 1;
          res.status = RES_INSERTED;
          res.position = POS_W'(n);
        end
      end
      REQ_DELETE: begin
        if (hit < 0) begin
          res.status = RES_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < n; i++) key_store[bkt][i] = key_store[bkt][i + 1];
          chain_len[bkt] = n - 1;
          res.status = RES_DELETED;
          res.position = POS_W'(hit);
        end
      end
      default: begin
        // The unused request kind behaves as a lookup.
        if (hit < 0) begin
          res.status = RES_NOT_FOUND;
        end else begin
          res.status = RES_FOUND;
          res.position = POS_W'(hit);
        end
      end
    endcase
    pending_results = {pending_results, res};
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (err_count < MAX_SHOWN) begin
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  task automatic check_result(input resp_t got);
    resp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected word", 16'(got), 16'd0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      report_mismatch("status", 16'(got.status), 16'(want.status));
    end
    if (got.bucket !== want.bucket) begin
      report_mismatch("bucket", 16'(got.bucket), 16'(want.bucket));
    end
    if (got.position !== want.position) begin
      report_mismatch("position", 16'(got.position), 16'(want.position));
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    int sel;
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
    if (ready_hold == 0) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(1, 20);
      end else if (sel < 92) begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(20, 60);
      end
    end else begin
      ready_hold--;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [TYPE_W-1:0] sym_type);
    req_t r;
    int   gap;
    r.req_type = kind;
    r.symbol_key = key;
    r.entry_type = sym_type;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(r);
  endtask

  // Holds the sender off until every outstanding result word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (pending_results.size() != 0);
  endtask

  task automatic test_empty_table();
    logic [KEY_W-1:0] sym;
    sym = make_name(3);
    send_request(REQ_LOOKUP, sym, '0);
    send_request(REQ_DELETE, sym, '0);
  endtask

  task automatic test_extremes();
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_LOOKUP, '0, '1);
    send_request(REQ_LOOKUP, '1, '0);
    send_request(REQ_INSERT, '1, {$urandom, $urandom});
  endtask

  task automatic test_bucket_full();
    while (chain_len[FILL_BUCKET] < CHAIN_SLOTS) begin
      send_request(REQ_INSERT, make_key_in(FILL_BUCKET, 8), {$urandom, $urandom});
    end
    send_request(REQ_INSERT, make_key_in(FILL_BUCKET, 4), {$urandom, $urandom});
    // A key already stored reports its slot even when the chain is full.
    send_request(REQ_INSERT, key_store[FILL_BUCKET][5], '0);
  endtask

  task automatic test_delete_shift();
    send_request(REQ_DELETE, key_store[FILL_BUCKET][3], '0);
    send_request(REQ_LOOKUP, key_store[FILL_BUCKET][3], '0);
    send_request(REQ_DELETE, key_store[FILL_BUCKET][chain_len[FILL_BUCKET] - 1], '0);
    send_request(REQ_DELETE, key_store[FILL_BUCKET][0], '0);
  endtask

  task automatic test_unused_kind();
    send_request(REQ_UNUSED, key_store[FILL_BUCKET][0], '1);
    send_request(REQ_UNUSED, make_name(8), '0);
  endtask

  // Each round works on a fresh key pool with a few crowded buckets, then
  // empties the table so the next round starts clean.
  task automatic test_random_traffic(input int rounds, input int per_round);
    int hot [3];
    int sel;
    int idx;
    logic [REQ_W-1:0] kind;
    logic [KEY_W-1:0] key;
    for (int rnd = 0; rnd < rounds; rnd++) begin
      foreach (hot[h]) hot[h] = $urandom_range(0, NUM_BUCKETS - 1);
      for (int i = 0; i < POOL_SIZE; i++) begin
        if (i < 36) key_pool[i] = make_key_in(hot[i / 12], $urandom_range(1, 8));
        else key_pool[i] = make_name($urandom_range(1, 8));
      end
      for (int i = 0; i < per_round; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) kind = REQ_INSERT;
        else if (sel < 70) kind = REQ_LOOKUP;
        else if (sel < 95) kind = REQ_DELETE;
        else kind = REQ_UNUSED;
        if ($urandom_range(0, 99) < ((kind == REQ_INSERT) ? 5 : 15)) key = {$urandom, $urandom};
        else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(kind, key, {$urandom, $urandom});
      end
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        while (chain_len[b] > 0) begin
          idx = $urandom_range(0, chain_len[b] - 1);
          send_request(REQ_DELETE, key_store[b][idx], {$urandom, $urandom});
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_extremes();
    test_bucket_full();
    test_delete_shift();
    test_unused_kind();
    drain_results();
    test_random_traffic(5, 340);

    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (pending_results.size() != 0);
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/chst_pkg.sv
rtl/core/chst_ram.sv
rtl/core/chst_ctrl.sv
rtl/core/chst_datapath.sv
rtl/core/chained_hash_symbol_table.sv
test/tb_top.sv
